FILE: hdl/rdiv_pkg.sv
// rdiv_pkg: shared types, opcodes and width constants for the restoring divider
// no dependencies
`timescale 1ns / 1ps
package rdiv_pkg;
    localparam int unsigned DATA_WIDTH_DEF = 64;
    localparam int unsigned FIFO_DEPTH_DEF = 2;
    localparam int unsigned PORT_WIDTH     = 64;

    typedef enum logic [1:0] {
        OP_UQUO = 2'd0,
        OP_UREM = 2'd1,
        OP_SQUO = 2'd2,
        OP_SREM = 2'd3
    } op_t;
endpackage

FILE: hdl/rdiv_if.sv
// rdiv_req_if / rdiv_rsp_if: valid/ready channels of the divider
// uses rdiv_pkg
`timescale 1ns / 1ps
interface rdiv_req_if;
    import rdiv_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [PORT_WIDTH-1:0] dividend;
    logic [PORT_WIDTH-1:0] divisor;
    modport source (output valid, opcode, dividend, divisor, input ready);
    modport sink   (input valid, opcode, dividend, divisor, output ready);
endinterface

interface rdiv_rsp_if;
    import rdiv_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [PORT_WIDTH-1:0] result;
    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

FILE: hdl/rdiv_front.sv
// rdiv_front: takes requests, reduces signed operands to magnitudes, records result signs
// uses rdiv_pkg
`timescale 1ns / 1ps
module rdiv_front
    import rdiv_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rdiv_req_if.sink              req,
    output logic                  fv,
    input  logic                  fr,
    output logic [2*DATA_WIDTH+1:0] fdata
);
    logic                    v_reg;
    logic [2*DATA_WIDTH+1:0] d_reg;
    logic [DATA_WIDTH-1:0]   n, d, nm, dm;
    logic                    sgn, nneg, dneg, is_rem, neg_res;

    always_comb
    begin
        n      = req.dividend[DATA_WIDTH-1:0];
        d      = req.divisor[DATA_WIDTH-1:0];
        sgn    = req.opcode[1];
        is_rem = req.opcode[0];
        nneg   = sgn & n[DATA_WIDTH-1];
        dneg   = sgn & d[DATA_WIDTH-1];
        nm     = nneg ? (~n + 1'b1) : n;
        dm     = dneg ? (~d + 1'b1) : d;
        // remainder follows dividend; quotient sign is the xor
        neg_res = is_rem ? nneg : (nneg ^ dneg);
    end

    assign req.ready = !v_reg || fr;
    assign fv        = v_reg;
    assign fdata     = d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (req.ready)
            v_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            d_reg <= {is_rem, neg_res, nm, dm};
    end
endmodule

FILE: hdl/rdiv_fifo.sv
// rdiv_fifo: short decoupling queue between front and back
// uses rdiv_pkg
`timescale 1ns / 1ps
module rdiv_fifo
    import rdiv_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             push, pop;

    assign in_ready  = cnt_reg != AW'(0) + (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_data;
    end
endmodule

FILE: hdl/rdiv_back.sv
// rdiv_back: pipelined restoring recurrence, one bit step per stage, sign fix and output register
// uses rdiv_pkg
`timescale 1ns / 1ps
module rdiv_back
    import rdiv_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2*DATA_WIDTH+1:0] in_data,
    rdiv_rsp_if.source              rsp
);
    localparam int unsigned W = DATA_WIDTH;

    // stage s holds partial remainder (W bits), shifting dividend/quotient word, divisor
    logic             v_reg   [W+1];
    logic [W-1:0]     r_reg   [W+1];
    logic [W-1:0]     nq_reg  [W+1];
    logic [W-1:0]     d_reg   [W+1];
    logic             rem_reg [W+1];
    logic             neg_reg [W+1];
    logic             adv;

    logic             ov_reg;
    logic [W-1:0]     res_reg;
    logic [W-1:0]     q, r, sel;

    // whole pipe moves together whenever the output slot can take data
    assign adv      = !ov_reg || rsp.ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= W; s++)
                v_reg[s] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= W; s++)
                v_reg[s] <= v_reg[s-1];
            ov_reg <= v_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg[0]   <= '0;
            nq_reg[0]  <= in_data[2*W-1:W];
            d_reg[0]   <= in_data[W-1:0];
            rem_reg[0] <= in_data[2*W+1];
            neg_reg[0] <= in_data[2*W];
        end
    end

    genvar g;
    generate
        for (g = 0; g < W; g++)
        begin : g_step
            logic [W:0] sh, df;
            logic       ge;
            always_comb
            begin
                // shifted remainder carries one extra bit so the compare is exact
                sh = {r_reg[g], nq_reg[g][W-1]};
                df = sh - {1'b0, d_reg[g]};
                ge = !df[W];
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r_reg[g+1]   <= ge ? df[W-1:0] : sh[W-1:0];
                    nq_reg[g+1]  <= {nq_reg[g][W-2:0], ge};
                    d_reg[g+1]   <= d_reg[g];
                    rem_reg[g+1] <= rem_reg[g];
                    neg_reg[g+1] <= neg_reg[g];
                end
            end
        end
    endgenerate

    always_comb
    begin
        // restoring by zero already yields all ones and the dividend
        q   = nq_reg[W];
        r   = r_reg[W];
        sel = rem_reg[W] ? r : q;
        if (neg_reg[W])
            sel = ~sel + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= sel;
    end

    assign rsp.valid  = ov_reg;
    assign rsp.result = PORT_WIDTH'(res_reg);
endmodule

FILE: hdl/restoring_divider_64.sv
// restoring_divider_64: top level, front end, queue and pipelined divide back end
// uses rdiv_pkg, rdiv_if, rdiv_front, rdiv_fifo, rdiv_back
`timescale 1ns / 1ps
// Divides a DATA_WIDTH-bit dividend by a divisor per opcode: unsigned or signed quotient
// or remainder. One transaction is accepted every cycle while the output is not stalled;
// the back end has DATA_WIDTH restoring stages, one quotient bit per stage. Division by
// zero gives all ones (unsigned quotient), -1/+1 (signed quotient) or the dividend
// (remainder); the minimum value over -1 wraps.
module restoring_divider_64
    import rdiv_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rdiv_req_if.sink   req,
    rdiv_rsp_if.source rsp
);
    localparam int unsigned FW = 2*DATA_WIDTH + 2;
    logic          fv, fr, qv, qr;
    logic [FW-1:0] fd, qd;

    rdiv_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .req(req), .fv(fv), .fr(fr), .fdata(fd)
    );

    rdiv_fifo #(.WIDTH(FW), .DEPTH(FIFO_DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(fv), .in_ready(fr), .in_data(fd),
        .out_valid(qv), .out_ready(qr), .out_data(qd)
    );

    rdiv_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(qv), .in_ready(qr), .in_data(qd), .rsp(rsp)
    );
endmodule
